>>> rtl/esdt_pkg.sv
// Shared types and constants of the event subscriber dispatch table.
// Holds the status codes, the per-cell control word and the default sizes.
// No dependencies.
`default_nettype none

package esdt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF = 16;
	localparam int HANDLE_BITS_DEF = 8;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NONE    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// Control word broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;   // sorted insert of the new word
		logic rotate;   // every cell takes its right-hand neighbor
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/esdt_cell.sv
// One entry of the subscription chain: an event id and a subscriber handle.
// Depends on esdt_pkg for the control word.
`default_nettype none

module esdt_cell #(
	parameter int IDX = 0,
	parameter int ID_BITS = 16,
	parameter int HANDLE_BITS = 8,
	parameter int CNT_BITS = 5
) (
	input  wire logic                    clk,
	input  wire esdt_pkg::cell_ctrl_t    ctrl,
	input  wire logic [CNT_BITS-1:0]     count,
	input  wire logic [ID_BITS-1:0]      new_id,
	input  wire logic [HANDLE_BITS-1:0]  new_handle,
	input  wire logic                    prev_gt,
	input  wire logic                    prev_occ,
	input  wire logic [ID_BITS-1:0]      prev_id,
	input  wire logic [HANDLE_BITS-1:0]  prev_handle,
	input  wire logic [ID_BITS-1:0]      next_id,
	input  wire logic [HANDLE_BITS-1:0]  next_handle,
	output logic [ID_BITS-1:0]           id,
	output logic [HANDLE_BITS-1:0]       handle,
	output logic                         occ,
	output logic                         gt
);
	import esdt_pkg::*;

	localparam logic [CNT_BITS-1:0] IDX_C = CNT_BITS'(IDX);

	logic [ID_BITS-1:0]     id_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// The entry is live when it lies below the entry count. A live entry with
	// a larger id moves one place right on an insert.
	assign occ = count > IDX_C;
	assign gt = occ && (id_q > new_id);
	assign id = id_q;
	assign handle = handle_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_gt) begin
				id_q <= prev_id;
				handle_q <= prev_handle;
			end else if (gt || (!occ && prev_occ)) begin
				id_q <= new_id;
				handle_q <= new_handle;
			end
		end else if (ctrl.rotate) begin
			id_q <= next_id;
			handle_q <= next_handle;
		end
	end

endmodule

`default_nettype wire

>>> rtl/event_subscriber_dispatch_table.sv
// Top level of the event subscriber dispatch table: a chain of esdt_cell
// entries kept sorted by event id, and the command and delivery control.
// Depends on esdt_pkg and esdt_cell.
//
// Usage. A command word is taken at a rising edge where start is high and
// busy is low. A subscribe (command 0) inserts the handle into the chain in
// id order, after all entries with an equal id, so equal ids are delivered
// in subscription order. A publish (command 1) reports every handle stored
// under the id. Results appear on status, target_handle, entry_count and
// last, each for exactly one cycle marked by result_strobe; the receiver
// cannot hold them off, and last marks the final result of a command.
//
// Latency and throughput. A subscribe, an invalid id, a full table or a
// publish that matches nothing gives its single result in the cycle after
// the command is taken, and busy stays low, so such a command can be given
// every cycle. A publish that matches rotates the whole chain once around,
// one place per cycle, and reports the entry at the head whenever it
// matches; it keeps busy high until the rotation is complete, and the next
// command can be taken as soon as busy is low again. Its results show up
// as the matching entries pass the head.
//
// Reset. arst_n clears the entry count, the control state and the result
// strobe. The entry storage itself is not cleared: entries at and above the
// count are never looked at, so their contents do not matter.
`default_nettype none

module event_subscriber_dispatch_table #(
	parameter int TABLE_DEPTH = esdt_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS = esdt_pkg::ID_BITS_DEF,
	parameter int HANDLE_BITS = esdt_pkg::HANDLE_BITS_DEF,
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    command,
	input  wire logic [ID_BITS-1:0]      event_id,
	input  wire logic [HANDLE_BITS-1:0]  subscriber_handle,
	output logic                         result_strobe,
	output esdt_pkg::status_t            status,
	output logic [HANDLE_BITS-1:0]       target_handle,
	output logic [CNT_BITS-1:0]          entry_count,
	output logic                         last
);
	import esdt_pkg::*;

	// Step counter of the rotation; one step per entry of the chain.
	localparam int STEP_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	// The entry that follows the head, used to see whether a match is the last.
	localparam int NEXT_IDX = 1 % TABLE_DEPTH;
	localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_DEPTH);
	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(TABLE_DEPTH - 1);

	typedef enum logic {
		IDLE,
		SCAN
	} state_t;

	state_t                  state_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [STEP_BITS-1:0]    step_q;
	logic [ID_BITS-1:0]      pub_id_q;
	logic                    strobe_q;
	status_t                 status_q;
	logic [HANDLE_BITS-1:0]  target_q;
	logic [CNT_BITS-1:0]     count_out_q;
	logic                    last_q;

	logic [ID_BITS-1:0]      cell_id [TABLE_DEPTH];
	logic [HANDLE_BITS-1:0]  cell_handle [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  cell_occ;
	logic [TABLE_DEPTH-1:0]  cell_gt;
	logic [TABLE_DEPTH-1:0]  cell_match;

	cell_ctrl_t              ctrl;
	logic                    accept;
	logic                    id_zero;
	logic                    full;
	logic                    any_match;
	logic                    head_match;
	logic                    head_last;
	logic [CNT_BITS:0]       step_ext;

	assign accept = start && !busy;
	assign id_zero = (event_id == '0);
	assign full = (count_q == FULL_COUNT);

	// The insert happens in the very cycle the subscribe is taken; during a
	// delivery scan the chain turns one place per cycle.
	assign ctrl.insert = accept && !command && !id_zero && !full;
	assign ctrl.rotate = (state_q == SCAN);

	// The chain of entries. Each cell sees its left neighbor for the shift
	// of an insert and its right neighbor for the rotation; the last cell
	// wraps around to the head.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic                   prev_gt;
		logic                   prev_occ;
		logic [ID_BITS-1:0]     prev_id;
		logic [HANDLE_BITS-1:0] prev_handle;

		if (i == 0) begin : g_head
			assign prev_gt = 1'b0;
			assign prev_occ = 1'b1;
			assign prev_id = '0;
			assign prev_handle = '0;
		end else begin : g_body
			assign prev_gt = cell_gt[i-1];
			assign prev_occ = cell_occ[i-1];
			assign prev_id = cell_id[i-1];
			assign prev_handle = cell_handle[i-1];
		end

		esdt_cell #(
			.IDX(i),
			.ID_BITS(ID_BITS),
			.HANDLE_BITS(HANDLE_BITS),
			.CNT_BITS(CNT_BITS)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.count(count_q),
			.new_id(event_id),
			.new_handle(subscriber_handle),
			.prev_gt(prev_gt),
			.prev_occ(prev_occ),
			.prev_id(prev_id),
			.prev_handle(prev_handle),
			.next_id(cell_id[(i + 1) % TABLE_DEPTH]),
			.next_handle(cell_handle[(i + 1) % TABLE_DEPTH]),
			.id(cell_id[i]),
			.handle(cell_handle[i]),
			.occ(cell_occ[i]),
			.gt(cell_gt[i])
		);

		// Only live entries take part in the lookup of a publish.
		assign cell_match[i] = cell_occ[i] && (cell_id[i] == event_id);
	end

	assign any_match = |cell_match;

	// At rotation step k the head holds the entry that sat at place k when
	// the scan began, so it is live when k is below the count. A match is
	// the final one when no live entry with the same id follows it.
	assign step_ext = (CNT_BITS + 1)'(step_q);
	assign head_match = (step_ext < {1'b0, count_q}) && (cell_id[0] == pub_id_q);
	assign head_last = ((step_ext + 1'b1) >= {1'b0, count_q})
		|| (cell_id[NEXT_IDX] != pub_id_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			step_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					// A publish that matches gives its words from the scan instead.
					strobe_q <= accept && !(command && !id_zero && any_match);
					if (accept) begin
						target_q <= '0;
						last_q <= 1'b1;
						if (id_zero) begin
							status_q <= ST_INVALID;
							count_out_q <= count_q;
						end else if (!command) begin
							if (full) begin
								status_q <= ST_FULL;
								count_out_q <= count_q;
							end else begin
								status_q <= ST_OK;
								count_q <= count_q + 1'b1;
								count_out_q <= count_q + 1'b1;
							end
						end else if (!any_match) begin
							status_q <= ST_NONE;
							count_out_q <= count_q;
						end else begin
							// Matches exist: results come out of the scan.
							pub_id_q <= event_id;
							step_q <= '0;
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					strobe_q <= head_match;
					status_q <= ST_OK;
					target_q <= cell_handle[0];
					count_out_q <= count_q;
					last_q <= head_last;
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == SCAN);
	assign result_strobe = strobe_q;
	assign status = status_q;
	assign target_handle = target_q;
	assign entry_count = count_out_q;
	assign last = last_q;

endmodule

`default_nettype wire

>>> rtl/esdt_checker.sv
// Port-level checks of the event subscriber dispatch table, bound to the top.
// Depends on esdt_pkg and event_subscriber_dispatch_table.
`default_nettype none

module esdt_checker #(
	parameter int TABLE_DEPTH = esdt_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS = esdt_pkg::ID_BITS_DEF,
	parameter int HANDLE_BITS = esdt_pkg::HANDLE_BITS_DEF,
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1)
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    command,
	input wire logic [ID_BITS-1:0]      event_id,
	input wire logic                    result_strobe,
	input wire esdt_pkg::status_t       status,
	input wire logic [HANDLE_BITS-1:0]  target_handle,
	input wire logic [CNT_BITS-1:0]     entry_count,
	input wire logic                    last
);
	import esdt_pkg::*;

	// A subscribe or an invalid id always answers with one final word at once.
	a_single_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (!command || event_id == '0))
		|=> (result_strobe && last))
		else $error("single-word command did not answer in the next cycle");

	// More words of a delivery are still to come, so the block must be busy.
	a_more_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |-> busy)
		else $error("non-final word shown while not busy");

	// Every error word is a single final word with no handle.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && status != ST_OK) |-> (last && target_handle == '0))
		else $error("error word is not a single final word");

	// The count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (entry_count <= CNT_BITS'(TABLE_DEPTH)))
		else $error("entry count beyond table depth");

	// A rising busy only follows a publish that was taken.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && command && event_id != '0))
		else $error("busy rose without a publish");

endmodule

bind event_subscriber_dispatch_table esdt_checker #(
	.TABLE_DEPTH(TABLE_DEPTH),
	.ID_BITS(ID_BITS),
	.HANDLE_BITS(HANDLE_BITS)
) u_esdt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.command(command),
	.event_id(event_id),
	.result_strobe(result_strobe),
	.status(status),
	.target_handle(target_handle),
	.entry_count(entry_count),
	.last(last)
);

`default_nettype wire
